// File: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger: payload structs,
// register map, trigger widths and the fixed-point constants of the range
// conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // Number of sensor channels carried by one tick. The payload structs name
  // each channel's fields, so this is fixed with them.
  localparam int unsigned SENSORS = 3;

  // Default echo counter width.
  localparam int unsigned LENGTH_BITS_DEF = 16;

  // Trigger configuration.
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned PULSE_W  = 8;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500000);
  localparam logic [PULSE_W-1:0]  PULSE_RESET  = PULSE_W'(10);

  // APB register map: one 32-bit register per word.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [0:0] {
    REG_PERIOD = 1'b0,
    REG_PULSE  = 1'b1
  } cfg_reg_e;

  // Range conversion: range = floor(len * 16 / 58) = floor(len * 8 / 29),
  // saturated at 15 bits.
  localparam int unsigned RANGE_W   = 15;
  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
  localparam int unsigned DIVISOR   = 29;
  localparam int unsigned SCALE_SH  = 3;
  // Smallest length whose range no longer fits in RANGE_W bits.
  localparam int unsigned SAT_LEN   = ((2 ** RANGE_W) * DIVISOR) >> SCALE_SH;
  localparam int unsigned LENC_W    = $clog2(SAT_LEN);
  localparam int unsigned X_W       = LENC_W + SCALE_SH;
  // Reciprocal of the divisor, rounded down; the estimate is at most one low.
  localparam int unsigned RECIP_SH  = 25;
  localparam int unsigned RECIP_W   = 21;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH) / DIVISOR);

  typedef struct packed {
    logic echo_level_a;
    logic echo_level_b;
    logic echo_level_c;
  } uer_in_t;

  typedef struct packed {
    logic               trigger_out;
    logic               range_valid_a;
    logic [RANGE_W-1:0] range_a;
    logic               range_valid_b;
    logic [RANGE_W-1:0] range_b;
    logic               range_valid_c;
    logic [RANGE_W-1:0] range_c;
  } uer_out_t;

  // Pipeline enables handed from the top level to every lane.
  typedef struct packed {
    logic accept;
    logic s1_en;
    logic s2_en;
  } pipe_ctrl_t;

  // What one lane reports for one tick.
  typedef struct packed {
    logic               valid;
    logic [RANGE_W-1:0] value;
  } lane_res_t;

endpackage

`default_nettype wire

// File: rtl/uer_trig.sv
// ----------------------------------------------------------------------------
// uer_trig
// Shared trigger generator: a period counter that reloads a pulse countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_trig (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            accept_i,
  input  wire  [uer_pkg::PERIOD_W-1:0]   period_i,
  input  wire  [uer_pkg::PULSE_W-1:0]    pulse_i,
  output logic                           trigger_o
);
  import uer_pkg::*;

  logic [PERIOD_W-1:0] count_q, count_d, count_inc;
  logic [PULSE_W-1:0]  left_q, left_d, left_cur;

  always_comb begin
    count_inc = count_q + 1'b1;
    count_d   = count_inc;
    left_cur  = left_q;
    if (count_inc >= period_i) begin
      count_d  = '0;
      left_cur = pulse_i;
    end
    trigger_o = (left_cur != '0);
    left_d    = trigger_o ? left_cur - 1'b1 : left_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/uer_lane.sv
// ----------------------------------------------------------------------------
// uer_lane
// One echo channel: edge detection, pulse timer and a two-stage
// reciprocal-multiply conversion of the pulse length into a range.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_lane #(
  parameter int unsigned LENGTH_BITS = uer_pkg::LENGTH_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire uer_pkg::pipe_ctrl_t  ctrl_i,
  input  wire                       echo_i,
  output uer_pkg::lane_res_t        res_o
);
  import uer_pkg::*;

  localparam int unsigned CMP_W  = (LENGTH_BITS > LENC_W) ? LENGTH_BITS : LENC_W;
  localparam int unsigned PROD_W = X_W + RECIP_W;

  // Echo timer state.
  logic                   last_q, armed_q, armed_d;
  logic [LENGTH_BITS-1:0] len_q, len_d, len_inc;
  logic                   rise, fall, report;

  // Conversion.
  logic [CMP_W-1:0]  len_ext;
  logic              sat;
  logic [LENC_W-1:0] lenc;
  logic [X_W-1:0]    x;
  logic [PROD_W-1:0] prod;

  logic               s1_rep_q, s1_sat_q;
  logic [RANGE_W-1:0] s1_q0_q;
  logic [X_W-1:0]     s1_x_q;

  logic [X_W-1:0]     q0_x_div, rem;
  logic [RANGE_W-1:0] quot;

  logic               res_valid_q;
  logic [RANGE_W-1:0] res_value_q;

  always_comb begin
    rise    = echo_i & ~last_q;
    fall    = ~echo_i & last_q;
    len_inc = (len_q == '1) ? len_q : len_q + 1'b1;
    armed_d = armed_q;
    len_d   = len_q;
    report  = 1'b0;
    if (rise) begin
      armed_d = 1'b1;
      len_d   = '0;
    end else if (armed_q) begin
      len_d = len_inc;
      if (fall) begin
        report  = (len_inc != '0);
        armed_d = 1'b0;
      end
    end
  end

  // Stage one: clamp and multiply by the reciprocal.
  always_comb begin
    len_ext = CMP_W'(len_inc);
    sat     = (len_ext >= CMP_W'(SAT_LEN));
    lenc    = sat ? '0 : len_ext[LENC_W-1:0];
    x       = {lenc, {SCALE_SH{1'b0}}};
    prod    = PROD_W'(x) * PROD_W'(RECIP);
  end

  // Stage two: the estimate is exact or one low; fix it with one compare.
  always_comb begin
    q0_x_div = X_W'(s1_q0_q) * X_W'(DIVISOR);
    rem      = s1_x_q - q0_x_div;
    quot     = (rem >= X_W'(DIVISOR)) ? s1_q0_q + 1'b1 : s1_q0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      armed_q     <= 1'b0;
      len_q       <= '0;
      s1_rep_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.accept) begin
        last_q  <= echo_i;
        armed_q <= armed_d;
        len_q   <= len_d;
      end
      if (ctrl_i.s1_en) begin
        s1_rep_q <= ctrl_i.accept & report;
      end
      if (ctrl_i.s2_en) begin
        res_valid_q <= s1_rep_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      s1_sat_q <= sat;
      s1_q0_q  <= prod[RECIP_SH +: RANGE_W];
      s1_x_q   <= x;
    end
    if (ctrl_i.s2_en) begin
      if (!s1_rep_q) begin
        res_value_q <= '0;
      end else if (s1_sat_q) begin
        res_value_q <= RANGE_MAX;
      end else begin
        res_value_q <= quot;
      end
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.value = res_value_q;

endmodule

`default_nettype wire

// File: rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: three-channel ultrasonic echo timer and range unit.
// Path: a tick's result goes through the stage-one registers and then the
// output register before it is offered on the result side.
// Throughput: one tick per cycle; a stall on the result side holds one tick
// in the stage-one registers and only then pushes back on the input side.
// Reset (rst_ni, asynchronous, active low) clears the timers, the trigger
// counter and the pipeline valids and loads the trigger registers' defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int unsigned LENGTH_BITS = uer_pkg::LENGTH_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Tick input channel.
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire uer_pkg::uer_in_t         in_data_i,
  // Result channel.
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output uer_pkg::uer_out_t             out_data_o,
  // Configuration port.
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [uer_pkg::ADDR_W-1:0]    paddr,
  input  wire  [uer_pkg::DATA_W-1:0]    pwdata,
  output logic [uer_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import uer_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers. The register is picked by the word address;
  // the byte offset within the word is ignored. The port never waits.
  // ---------------------------------------------------------------------
  logic [PERIOD_W-1:0] period_q;
  logic [PULSE_W-1:0]  pulse_q;
  logic                cfg_wr;
  cfg_reg_e            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      pulse_q  <= PULSE_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
        REG_PULSE:  pulse_q  <= pwdata[PULSE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PERIOD: prdata = DATA_W'(period_q);
      REG_PULSE:  prdata = DATA_W'(pulse_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Stage one holds the multiply products, stage two is
  // the output register. Each stage loads whenever it is empty or the stage
  // after it moves, so a tick is taken every cycle unless both stages are
  // full and the result side is stalling.
  // ---------------------------------------------------------------------
  logic       s1_valid_q, out_valid_q;
  logic       out_ready;
  pipe_ctrl_t ctrl;

  assign out_ready   = ~out_valid_q | ~out_stall_i;
  assign ctrl.s2_en  = out_ready;
  assign ctrl.s1_en  = ~s1_valid_q | out_ready;
  assign ctrl.accept = in_valid_i & ctrl.s1_en;
  assign in_stall_o  = ~ctrl.s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.s1_en) begin
        s1_valid_q <= ctrl.accept;
      end
      if (ctrl.s2_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------
  // Shared trigger. Its level for a tick is decided at the input transfer
  // and then rides along the pipeline with the lanes' results.
  // ---------------------------------------------------------------------
  logic trig_now, s1_trig_q, out_trig_q;

  uer_trig u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (ctrl.accept),
    .period_i  (period_q),
    .pulse_i   (pulse_q),
    .trigger_o (trig_now)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.s1_en) begin
      s1_trig_q <= trig_now;
    end
    if (ctrl.s2_en) begin
      out_trig_q <= s1_trig_q;
    end
  end

  // ---------------------------------------------------------------------
  // Echo lanes: one timer and range converter per sensor, all stepping on
  // the same transfer.
  // ---------------------------------------------------------------------
  logic [SENSORS-1:0] echo;
  lane_res_t          lane_res [SENSORS];

  assign echo[0] = in_data_i.echo_level_a;
  assign echo[1] = in_data_i.echo_level_b;
  assign echo[2] = in_data_i.echo_level_c;

  for (genvar k = 0; k < SENSORS; k++) begin : g_lane
    uer_lane #(
      .LENGTH_BITS (LENGTH_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .echo_i (echo[k]),
      .res_o  (lane_res[k])
    );
  end

  // ---------------------------------------------------------------------
  // Merge: the lanes' registered results and the trigger level form one
  // result item. A lane that did not finish an echo reports a zero range.
  // ---------------------------------------------------------------------
  always_comb begin
    out_data_o.trigger_out   = out_trig_q;
    out_data_o.range_valid_a = lane_res[0].valid;
    out_data_o.range_a       = lane_res[0].value;
    out_data_o.range_valid_b = lane_res[1].valid;
    out_data_o.range_b       = lane_res[1].value;
    out_data_o.range_valid_c = lane_res[2].valid;
    out_data_o.range_c       = lane_res[2].value;
  end

endmodule

`default_nettype wire

// File: rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks of the echo ranger, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_checker (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire                    in_stall_i,
  input  wire                    out_valid_i,
  input  wire                    out_stall_i,
  input  wire uer_pkg::uer_out_t out_data_i
);
  import uer_pkg::*;

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid_i & ~in_stall_i;
  assign out_xfer = out_valid_i & ~out_stall_i;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  // The input side only pushes back when a result is waiting on a stall.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled without a stalled result");

  // A result appearing on an empty output comes from an input transfer that went
  // through the stage-one registers into the output register without a stall.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer, 2))
    else $error("result appeared without a matching input transfer");

  // An echo needs a rising and a falling edge, so one channel cannot report
  // in two consecutive ticks.
  a_no_double_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_data_i.range_valid_a |=> !(out_xfer && out_data_i.range_valid_a))
    else $error("channel a reported on two consecutive ticks");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
